// File: design/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on signals named clk and rst in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, sampled on clk, switched off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check on clk that also runs during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/tlm_pkg.sv
// Shared types and constants for the two-list merge engine.
// No dependencies.
package tlm_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH_FIRST  = 2'd0,
    OP_PUSH_SECOND = 2'd1,
    OP_MERGE       = 2'd2
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] value;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_MERGE
  } back_state_e;

endpackage

// File: design/tlm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlm_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/tlm_front.sv
// Front end: accepts input items, drops unused operation codes and
// buffers the rest as commands in a short queue. Uses tlm_pkg.
module tlm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [1:0]          operation,
  input  logic signed [31:0]  value,
  output logic                full,
  output logic                cmd_valid,
  output tlm_pkg::cmd_t       cmd,
  input  logic                cmd_ready
);

  import tlm_pkg::*;

  cmd_t              slot [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [QPTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [QCNT_W-1:0] fill, fill_next;
  logic              accept;
  logic              enq;
  logic              deq;

  assign full      = (fill == QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (fill != '0);
  assign cmd       = slot[rd_ptr];
  assign accept    = push && !full;
  assign deq       = cmd_valid && cmd_ready;

  always_comb begin
    case (operation)
      OP_PUSH_FIRST, OP_PUSH_SECOND, OP_MERGE: enq = accept;
      default:                                 enq = 1'b0;  // drop unused code
    endcase
  end

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    fill_next   = fill;
    if (enq) begin
      wr_ptr_next = (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
    end
    if (deq) begin
      rd_ptr_next = (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
    end
    if (enq && !deq) begin
      fill_next = fill + QCNT_W'(1);
    end else if (!enq && deq) begin
      fill_next = fill - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      fill   <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      slot[wr_ptr] <= '{op: op_e'(operation), value: value};
    end
  end

endmodule

// File: design/tlm_back.sv
// Back end: stores pushed values in the two list RAMs and runs the merge,
// one result per cycle into the output register while that register is free or being popped. Uses tlm_pkg, tlm_ram.
module tlm_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  tlm_pkg::cmd_t       cmd,
  output logic                cmd_ready,
  output logic                empty,
  input  logic                pop,
  output logic signed [31:0]  merged_value,
  output logic                from_second,
  output logic                last
);

  import tlm_pkg::*;

  back_state_e       state, state_next;
  logic [CNT_W-1:0]  cnt_first, cnt_first_next;
  logic [CNT_W-1:0]  cnt_second, cnt_second_next;
  logic [CNT_W-1:0]  idx_first, idx_first_next;
  logic [CNT_W-1:0]  idx_second, idx_second_next;
  logic              out_valid, out_valid_next;
  logic [DATA_W-1:0] out_value, out_value_next;
  logic              out_second, out_second_next;
  logic              out_last, out_last_next;

  logic              we_first, we_second;
  logic [DATA_W-1:0] head_first, head_second;
  logic              out_ready;
  logic              take_first;

  tlm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_first_ram (
    .clk   (clk),
    .we    (we_first),
    .waddr (cnt_first[IDX_W-1:0]),
    .wdata (cmd.value),
    .raddr (idx_first_next[IDX_W-1:0]),
    .rdata (head_first)
  );

  tlm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_second_ram (
    .clk   (clk),
    .we    (we_second),
    .waddr (cnt_second[IDX_W-1:0]),
    .wdata (cmd.value),
    .raddr (idx_second_next[IDX_W-1:0]),
    .rdata (head_second)
  );

  assign cmd_ready    = (state == ST_IDLE);
  assign out_ready    = !out_valid || pop;
  assign empty        = !out_valid;
  assign merged_value = out_value;
  assign from_second  = out_second;
  assign last         = out_last;

  // Equal heads go to the second list.
  assign take_first = (idx_first < cnt_first) &&
                      ((idx_second >= cnt_second) ||
                       ($signed(head_first) < $signed(head_second)));

  always_comb begin
    state_next      = state;
    cnt_first_next  = cnt_first;
    cnt_second_next = cnt_second;
    idx_first_next  = idx_first;
    idx_second_next = idx_second;
    out_valid_next  = out_valid && !pop;
    out_value_next  = out_value;
    out_second_next = out_second;
    out_last_next   = out_last;
    we_first        = 1'b0;
    we_second       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_PUSH_FIRST: begin
              if (cnt_first < CNT_W'(LIST_DEPTH)) begin
                we_first       = 1'b1;
                cnt_first_next = cnt_first + CNT_W'(1);
              end
            end
            OP_PUSH_SECOND: begin
              if (cnt_second < CNT_W'(LIST_DEPTH)) begin
                we_second       = 1'b1;
                cnt_second_next = cnt_second + CNT_W'(1);
              end
            end
            OP_MERGE: begin
              // Nothing to emit when both lists are empty.
              if (cnt_first != '0 || cnt_second != '0) begin
                state_next = ST_PRIME;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_PRIME: begin
        // Let the RAM heads settle after the last writes.
        state_next = ST_MERGE;
      end
      ST_MERGE: begin
        if (out_ready) begin
          out_valid_next = 1'b1;
          if (take_first) begin
            out_value_next  = head_first;
            out_second_next = 1'b0;
            idx_first_next  = idx_first + CNT_W'(1);
          end else begin
            out_value_next  = head_second;
            out_second_next = 1'b1;
            idx_second_next = idx_second + CNT_W'(1);
          end
          out_last_next = (idx_first_next == cnt_first) && (idx_second_next == cnt_second);
          if (out_last_next) begin
            state_next      = ST_IDLE;
            cnt_first_next  = '0;
            cnt_second_next = '0;
            idx_first_next  = '0;
            idx_second_next = '0;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt_first  <= '0;
      cnt_second <= '0;
      idx_first  <= '0;
      idx_second <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cnt_first  <= cnt_first_next;
      cnt_second <= cnt_second_next;
      idx_first  <= idx_first_next;
      idx_second <= idx_second_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_value  <= out_value_next;
    out_second <= out_second_next;
    out_last   <= out_last_next;
  end

endmodule

// File: design/two_list_merge_engine.sv
// Two-list merge engine: push values into two sorted lists, then merge.
// Input queue: an item (operation, value) is taken on a clock edge with push
//   high and full low. Operation 0 appends to the first list, 1 to the
//   second list, 2 merges; code 3 is dropped. Pushes to a full list
//   (32 values) are dropped silently.
// Result queue: while empty is low the oldest result (merged_value,
//   from_second, last) is on the ports; pop takes it. last marks the end of
//   a merge run; on equal values the second list goes first.
// Throughput: one push per cycle while full is low. A merge holds the back end
//   in its prime and merge states, one result per cycle while pop keeps up,
//   paced by the single read port of each list RAM. With the back end idle,
//   the merge item passes the command queue, the prime state and the merge
//   state into the result register; a merge of two empty lists gives nothing.
// A two-entry command queue between front and back keeps input accepted
//   while a merge runs, until that queue fills.
// Stall: when pop stays low the result holds and the merge pauses; the
//   input side fills its queue and then raises full.
// Reset: rst (synchronous) empties both lists and both queues.
// Uses tlm_pkg, tlm_front, tlm_back.
module two_list_merge_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [1:0]         operation,
  input  logic signed [31:0] value,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] merged_value,
  output logic               from_second,
  output logic               last
);

  import tlm_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  tlm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .operation (operation),
    .value     (value),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  tlm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_ready    (cmd_ready),
    .empty        (empty),
    .pop          (pop),
    .merged_value (merged_value),
    .from_second  (from_second),
    .last         (last)
  );

endmodule

// File: design/tlm_checker.sv
// Port-level checks for two_list_merge_engine, bound to the top level.
// Uses assert_macros.svh.
`include "assert_macros.svh"

module tlm_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic signed [31:0] merged_value,
  input logic               from_second,
  input logic               last
);

  // Both queues come out of reset empty.
  `ASSERT_ALWAYS(a_reset_clear, $past(rst) |-> (empty && !full), "queues not clear after reset")

  // A stalled result holds.
  `ASSERT_CLK(a_stall_hold, (!empty && !pop) |=> (!empty && $stable(merged_value) && $stable(from_second) && $stable(last)), "result changed while stalled")

  // Within a run, results follow each other without a gap.
  `ASSERT_CLK(a_run_gapless, (!empty && pop && !last) |=> !empty, "gap inside a merge run")

endmodule

bind two_list_merge_engine tlm_checker u_checker (.*);

// File: test/merge_checker.sv
`timescale 1ns / 1ps
// Checker for the two-list merge engine: watches both queue interfaces, predicts merge output.
// Depends on tlm_pkg for list depth and operation codes.
module merge_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic [1:0]         operation,
  input  logic signed [31:0] value,
  input  logic               pop,
  input  logic               empty,
  input  logic signed [31:0] merged_value,
  input  logic               from_second,
  input  logic               last,
  output int                 fail_count,
  output int                 outstanding
);

  import tlm_pkg::*;

  typedef struct packed {
    logic signed [31:0] word;
    logic               second;
    logic               tail;
  } merge_out_t;

  logic signed [31:0] first_vals[$];
  logic signed [31:0] second_vals[$];
  merge_out_t         merge_expect[$];
  int                 errors;

  // Walk both lists head to head; the first list wins only when strictly smaller.
  task automatic predict_merge();
    int i;
    int j;
    int k;
    int total;
    bit take_first;
    merge_out_t item;
    i = 0;
    j = 0;
    k = 0;
    total = first_vals.size() + second_vals.size();
    while (i < first_vals.size() || j < second_vals.size()) begin
      take_first = (i < first_vals.size()) &&
                   (j >= second_vals.size() || first_vals[i] < second_vals[j]);
      if (take_first) begin
        item.word = first_vals[i];
        item.second = 1'b0;
        i++;
      end else begin
        item.word = second_vals[j];
        item.second = 1'b1;
        j++;
      end
      item.tail = (k + 1 == total);
      merge_expect.push_back(item);
      k++;
    end
    first_vals.delete();
    second_vals.delete();
  endtask

  task automatic take_request(input logic [1:0] op, input logic signed [31:0] val);
    if (op == OP_PUSH_FIRST) begin
      if (first_vals.size() < LIST_DEPTH) first_vals.push_back(val);
    end else if (op == OP_PUSH_SECOND) begin
      if (second_vals.size() < LIST_DEPTH) second_vals.push_back(val);
    end else if (op == OP_MERGE) begin
      predict_merge();
    end
  endtask

  task automatic check_result();
    merge_out_t want;
    if (merge_expect.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: value %0d from_second %0b last %0b",
                 merged_value, from_second, last);
    end else begin
      want = merge_expect.pop_front();
      if (want.word !== merged_value || want.second !== from_second ||
          want.tail !== last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected value %0d from_second %0b last %0b, got %0d %0b %0b",
                   want.word, want.second, want.tail, merged_value, from_second, last);
      end
    end
  endtask

  initial begin
    errors = 0;
    fail_count = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      first_vals.delete();
      second_vals.delete();
      merge_expect.delete();
      outstanding <= 0;
    end else begin
      if (push && !full) take_request(operation, value);
      if (pop && !empty) check_result();
      fail_count <= errors;
      outstanding <= merge_expect.size();
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Top of the merge engine test: clock, reset, request stimulus, result stalls, verdict.
// Depends on tlm_pkg, two_list_merge_engine and merge_checker.
module testbench;
  import tlm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic               clk;
  logic               rst;
  logic               push;
  logic [1:0]         operation;
  logic signed [31:0] value;
  logic               full;
  logic               empty;
  logic               pop;
  logic signed [31:0] merged_value;
  logic               from_second;
  logic               last;
  int                 fail_count;
  int                 outstanding;

  int burst_left;
  int items_sent;

  two_list_merge_engine dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .operation    (operation),
    .value        (value),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .merged_value (merged_value),
    .from_second  (from_second),
    .last         (last)
  );

  merge_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .operation    (operation),
    .value        (value),
    .pop          (pop),
    .empty        (empty),
    .merged_value (merged_value),
    .from_second  (from_second),
    .last         (last),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Drive one request at the falling edge and hold it until accepted.
  task automatic send_item(input logic [1:0] op, input int val);
    if (burst_left == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    push = 1'b1;
    operation = op;
    value = val;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Next value of a list: non-decreasing unless the set is meant to be unsorted.
  function automatic int pick_value(input int prev, input bit started, input bit sorted,
                                    input bit narrow);
    longint cand;
    if (!sorted) return $urandom;
    if (!started) return narrow ? $urandom_range(0, 16) - 8 : $urandom;
    cand = longint'(prev) + (narrow ? $urandom_range(0, 2) : $urandom_range(0, 32'h0fff_ffff));
    if (cand > 64'sh7fff_ffff) cand = 64'sh7fff_ffff;
    return int'(cand);
  endfunction

  // Receiver: alternate between eager, random and mostly stalled phases.
  initial begin
    int phase_left;
    int mode;
    phase_left = 0;
    mode = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        mode = $urandom_range(0, 2);
        phase_left = $urandom_range(16, 64);
      end
      phase_left--;
      case (mode)
        0: pop = 1'b1;
        1: pop = $urandom_range(0, 1);
        default: pop = ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  initial begin
    int set_idx;
    int n_first;
    int n_second;
    int ia;
    int ib;
    int prev_a;
    int prev_b;
    bit sorted;
    bit narrow;
    push = 1'b0;
    operation = OP_PUSH_FIRST;
    value = '0;
    rst = 1'b1;
    burst_left = 0;
    items_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: unused code, empty merge, extremes with ties, one-sided and unsorted lists.
    send_item(OP_UNUSED, 32'hffff_ffff);
    send_item(OP_MERGE, 0);
    send_item(OP_PUSH_FIRST, 32'h8000_0000);
    send_item(OP_PUSH_FIRST, -1);
    send_item(OP_PUSH_FIRST, 32'h7fff_ffff);
    send_item(OP_PUSH_SECOND, 32'h8000_0000);
    send_item(OP_PUSH_SECOND, 0);
    send_item(OP_PUSH_SECOND, 32'h7fff_ffff);
    send_item(OP_MERGE, 32'hffff_ffff);
    send_item(OP_PUSH_FIRST, 5);
    send_item(OP_MERGE, 0);
    send_item(OP_PUSH_SECOND, -7);
    send_item(OP_MERGE, 0);
    send_item(OP_PUSH_FIRST, 9);
    send_item(OP_PUSH_FIRST, -3);
    send_item(OP_PUSH_SECOND, 4);
    send_item(OP_PUSH_SECOND, -10);
    send_item(OP_MERGE, 0);
    send_item(OP_PUSH_FIRST, 1);
    send_item(OP_UNUSED, 5);
    send_item(OP_PUSH_SECOND, 1);
    send_item(OP_MERGE, 0);

    // Random sets: mostly small sorted lists, a few overfilled ones, some noise.
    set_idx = 0;
    while (items_sent < 250) begin
      n_first = (set_idx == 0 || $urandom_range(0, 19) == 0) ?
                $urandom_range(31, 35) : $urandom_range(0, 6);
      n_second = (set_idx == 1 || $urandom_range(0, 19) == 0) ?
                 $urandom_range(31, 35) : $urandom_range(0, 6);
      sorted = ($urandom_range(0, 7) != 0);
      narrow = $urandom_range(0, 1);
      ia = 0;
      ib = 0;
      prev_a = 0;
      prev_b = 0;
      while (ia < n_first || ib < n_second) begin
        if ($urandom_range(0, 15) == 0) send_item(OP_UNUSED, $urandom);
        if (ib >= n_second || (ia < n_first && $urandom_range(0, 1))) begin
          prev_a = pick_value(prev_a, ia != 0, sorted, narrow);
          send_item(OP_PUSH_FIRST, prev_a);
          ia++;
        end else begin
          prev_b = pick_value(prev_b, ib != 0, sorted, narrow);
          send_item(OP_PUSH_SECOND, prev_b);
          ib++;
        end
      end
      // Skip the merge now and then so lists carry over into the next set.
      if ($urandom_range(0, 9) != 0) send_item(OP_MERGE, $urandom);
      set_idx++;
    end
    send_item(OP_MERGE, $urandom);
    push = 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("two_list_merge_engine test passed");
    end else begin
      $display("two_list_merge_engine test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("two_list_merge_engine test failed");
    $finish;
  end

endmodule

// File: two_list_merge_engine.f
+incdir+design
design/tlm_pkg.sv
design/tlm_ram.sv
design/tlm_front.sv
design/tlm_back.sv
design/two_list_merge_engine.sv
design/tlm_checker.sv
test/merge_checker.sv
test/testbench.sv
